@@ rtl/blr_pkg.sv @@
// ----------------------------------------------------------------------------
// blr_pkg
// Shared types and widths for the Bresenham line rasterizer: the request and
// pixel transaction payloads, the walker state and the octant codes.
// ----------------------------------------------------------------------------
package blr_pkg;

  // Coordinate width of every endpoint and pixel field.
  localparam int unsigned CoordW = 12;
  // Endpoint difference, one bit wider than a coordinate.
  localparam int unsigned DiffW  = CoordW + 1;
  // Step terms 2*dy and -2*dx.
  localparam int unsigned StepW  = CoordW + 2;
  // Decision term.
  localparam int unsigned DecW   = CoordW + 4;

  typedef enum logic [0:0] {
    BLR_MODE_LOAD = 1'b0,
    BLR_MODE_STEP = 1'b1
  } blr_mode_e;

  typedef enum logic [1:0] {
    OCT_SHALLOW_UP   = 2'd0,
    OCT_SHALLOW_DOWN = 2'd1,
    OCT_STEEP_UP     = 2'd2,
    OCT_STEEP_DOWN   = 2'd3
  } blr_octant_e;

  typedef struct packed {
    blr_mode_e                mode;
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
  } blr_req_t;

  typedef struct packed {
    logic signed [CoordW-1:0] pixel_x;
    logic signed [CoordW-1:0] pixel_y;
    logic                     last_pixel;
  } blr_pix_t;

  typedef struct packed {
    logic signed [CoordW-1:0] walk_x;
    logic signed [CoordW-1:0] walk_y;
    logic signed [CoordW-1:0] target_x;
    logic signed [CoordW-1:0] target_y;
    logic signed [DecW-1:0]   decision;
    logic signed [StepW-1:0]  step_a;
    logic signed [StepW-1:0]  step_b;
    blr_octant_e              octant;
    logic                     active;
  } blr_state_t;

endpackage

@@ rtl/blr_step.sv @@
// ----------------------------------------------------------------------------
// blr_step
// Next-state and pixel logic for one request: line setup on a load, one
// walker advance on a step.
// ----------------------------------------------------------------------------
module blr_step (
  input  blr_pkg::blr_req_t   req_i,
  input  blr_pkg::blr_state_t state_i,
  output blr_pkg::blr_state_t state_o,
  output logic                pix_valid_o,
  output blr_pkg::blr_pix_t   pix_o
);

  logic                                 swap;
  logic signed [blr_pkg::CoordW-1:0]    x0, y0, x1, y1;
  logic signed [blr_pkg::DiffW-1:0]     dx, dy, ady;
  logic signed [blr_pkg::StepW-1:0]     a_init, b_init;
  logic signed [blr_pkg::DecW-1:0]      dx_d, dy_d;
  logic                                 steep, rising;

  // Line setup: order endpoints so x is non-decreasing.
  assign swap = req_i.start_x > req_i.end_x;
  assign x0   = swap ? req_i.end_x   : req_i.start_x;
  assign y0   = swap ? req_i.end_y   : req_i.start_y;
  assign x1   = swap ? req_i.start_x : req_i.end_x;
  assign y1   = swap ? req_i.start_y : req_i.end_y;

  assign dx     = blr_pkg::DiffW'(x1) - blr_pkg::DiffW'(x0);
  assign dy     = blr_pkg::DiffW'(y1) - blr_pkg::DiffW'(y0);
  assign ady    = dy[blr_pkg::DiffW-1] ? -dy : dy;
  assign a_init = $signed({dy, 1'b0});
  assign b_init = -$signed({dx, 1'b0});
  assign steep  = ady > dx;
  assign rising = a_init > 0;
  assign dx_d   = blr_pkg::DecW'(dx);
  assign dy_d   = blr_pkg::DecW'(dy);

  logic                               walking;
  logic signed [blr_pkg::DecW-1:0]    a_d, b_d;

  assign a_d = blr_pkg::DecW'(state_i.step_a);
  assign b_d = blr_pkg::DecW'(state_i.step_b);

  always_comb begin
    state_o     = state_i;
    pix_valid_o = 1'b0;
    pix_o       = '0;
    walking     = 1'b0;

    if (req_i.mode == blr_pkg::BLR_MODE_LOAD) begin
      state_o.walk_x   = x0;
      state_o.walk_y   = y0;
      state_o.target_x = x1;
      state_o.target_y = y1;
      state_o.step_a   = a_init;
      state_o.step_b   = b_init;
      state_o.active   = 1'b1;
      // Halves of even step terms are exact: A/2 = dy, B/2 = -dx.
      if (!steep) begin
        if (rising) begin
          state_o.octant   = blr_pkg::OCT_SHALLOW_UP;
          state_o.decision = dy_d + dy_d - dx_d;
        end else begin
          state_o.octant   = blr_pkg::OCT_SHALLOW_DOWN;
          state_o.decision = dy_d + dy_d + dx_d;
        end
      end else begin
        if (rising) begin
          state_o.octant   = blr_pkg::OCT_STEEP_UP;
          state_o.decision = dy_d - dx_d - dx_d;
        end else begin
          state_o.octant   = blr_pkg::OCT_STEEP_DOWN;
          state_o.decision = dy_d + dx_d + dx_d;
        end
      end
    end else if (state_i.active) begin
      case (state_i.octant)
        blr_pkg::OCT_SHALLOW_UP,
        blr_pkg::OCT_SHALLOW_DOWN: walking = state_i.walk_x < state_i.target_x;
        blr_pkg::OCT_STEEP_UP:     walking = state_i.walk_y < state_i.target_y;
        blr_pkg::OCT_STEEP_DOWN:   walking = state_i.walk_y > state_i.target_y;
        default:                   walking = 1'b0;
      endcase

      pix_valid_o = 1'b1;
      if (!walking) begin
        // End reached: emit the endpoint and drop back to idle.
        pix_o.pixel_x    = state_i.target_x;
        pix_o.pixel_y    = state_i.target_y;
        pix_o.last_pixel = 1'b1;
        state_o.active   = 1'b0;
      end else begin
        pix_o.pixel_x    = state_i.walk_x;
        pix_o.pixel_y    = state_i.walk_y;
        pix_o.last_pixel = 1'b0;
        case (state_i.octant)
          blr_pkg::OCT_SHALLOW_UP: begin
            state_o.walk_x   = state_i.walk_x + 1'b1;
            state_o.walk_y   = state_i.walk_y + (state_i.decision > 0 ? 1'b1 : 1'b0);
            state_o.decision = state_i.decision + a_d + (state_i.decision > 0 ? b_d : '0);
          end
          blr_pkg::OCT_SHALLOW_DOWN: begin
            state_o.walk_x   = state_i.walk_x + 1'b1;
            state_o.walk_y   = state_i.walk_y - (state_i.decision < 0 ? 1'b1 : 1'b0);
            state_o.decision = state_i.decision + a_d - (state_i.decision < 0 ? b_d : '0);
          end
          blr_pkg::OCT_STEEP_UP: begin
            state_o.walk_y   = state_i.walk_y + 1'b1;
            state_o.walk_x   = state_i.walk_x + (state_i.decision < 0 ? 1'b1 : 1'b0);
            state_o.decision = state_i.decision + b_d + (state_i.decision < 0 ? a_d : '0);
          end
          blr_pkg::OCT_STEEP_DOWN: begin
            state_o.walk_y   = state_i.walk_y - 1'b1;
            state_o.walk_x   = state_i.walk_x + (state_i.decision > 0 ? 1'b1 : 1'b0);
            state_o.decision = state_i.decision - b_d + (state_i.decision > 0 ? a_d : '0);
          end
          default: state_o = state_i;
        endcase
      end
    end
  end

endmodule

@@ rtl/bresenham_line_rasterizer_core.sv @@
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_core
// Integer midpoint line rasterizer emitting one pixel per step request on an active line.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the in_* channel (valid/ready). A load transaction
//   (mode = load) latches two endpoints, orders them by x and sets up the
//   decision term; it returns no pixel. Each step transaction (mode = step)
//   returns one pixel on the out_* channel; the final one is the endpoint
//   with last_pixel set, after which the walker is idle. A step while idle
//   returns nothing. A load while a line is active replaces that line.
//   Path: a step is held in the request register and its pixel in the
//   result register, from which it leaves on the out_* channel.
//   Throughput: one transaction per cycle while out_ready_i is high. Each
//   request is finished by a single pass through the step logic between the
//   two registers, and the walker state feeds back into itself through that logic.
//   Reset: rst_ni clears the walker state and both valid flags; the block
//   comes up idle with in_ready_o high.
//   Stall: while out_ready_i is low the pending pixel holds in the result
//   register, one more request is held in the request register, and only
//   then does in_ready_o drop.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  blr_pkg::blr_req_t in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output blr_pkg::blr_pix_t out_o
);

  // Request register.
  logic                in_valid_q;
  blr_pkg::blr_req_t   in_q;

  // Walker state.
  blr_pkg::blr_state_t state_q, state_d;

  // Result register.
  logic                out_valid_q;
  blr_pkg::blr_pix_t   out_q;

  // Step logic outputs.
  logic                pix_valid;
  blr_pkg::blr_pix_t   pix;

  logic                advance;
  logic                out_free;

  blr_step u_step (
    .req_i      (in_q),
    .state_i    (state_q),
    .state_o    (state_d),
    .pix_valid_o(pix_valid),
    .pix_o      (pix)
  );

  // The result slot is free when empty or being drained this cycle.
  assign out_free   = !out_valid_q || out_ready_i;
  // Process the held request only when its pixel has somewhere to go.
  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Payload only, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_i;
    end
  end

  // Commit the walker update once per processed request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && pix_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && pix_valid) begin
      out_q <= pix;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // Back-pressure only when both registers are full and the receiver stalls.
  a_ready_low_only_when_full : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_q && !out_ready_i)
  ) else $error("in_ready_o low without a full pipeline");

  // A load never produces a pixel.
  a_load_no_pixel : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (advance && in_q.mode == blr_pkg::BLR_MODE_LOAD) |-> !pix_valid
  ) else $error("load transaction produced a pixel");

  // The endpoint pixel leaves the walker idle.
  a_last_goes_idle : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (advance && pix_valid && pix.last_pixel) |=> !state_q.active
  ) else $error("walker still active after the last pixel");

  // A step while idle changes nothing.
  a_idle_step_holds : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (advance && in_q.mode == blr_pkg::BLR_MODE_STEP && !state_q.active)
      |=> $stable(state_q)
  ) else $error("idle step changed walker state");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bresenham_line_rasterizer_core. A directed table
// (idle steps, single-point line, extreme endpoints, load while active, all
// four octants) is followed by random line loads, each walked to its end or
// cut short by a new load, with noise items between them. Every accepted
// pixel is checked against a line-walk predictor. Both channels idle at
// random in two of three phases; the third runs both at full rate.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_ITEMS = 1400;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_REPORTS  = 10;

  // How a directed row is checked.
  typedef enum {
    EXP_FROM_WALK,  // take the pixel (or none) from the predictor
    EXP_NO_PIXEL,   // typed: the transaction returns nothing
    EXP_TYPED_PIXEL // typed: the pixel in the row
  } exp_kind_e;

  typedef struct {
    blr_pkg::blr_req_t req;
    exp_kind_e         kind;
    blr_pkg::blr_pix_t pix;
  } dir_row_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  blr_pkg::blr_req_t in_i        = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  blr_pkg::blr_pix_t out_o;

  // Predictor state: the walker as the block should hold it.
  blr_pkg::blr_state_t walker = '0;

  blr_pkg::blr_pix_t expected_pixels[$];
  dir_row_t          dir_rows[$];
  blr_pkg::blr_pix_t want;
  int unsigned mismatches    = 0;
  int unsigned pixels_seen   = 0;
  int unsigned cycle_count   = 0;
  int unsigned random_count  = 0;
  int unsigned lines_loaded  = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  bresenham_line_rasterizer_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  always #2 clk_i = ~clk_i;

  // Abort a run that stops making progress.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels still expected", cycle_count,
               expected_pixels.size());
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: stall the pixel channel at the rate of the current phase.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare every accepted pixel with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      pixels_seen++;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected pixel (%0d,%0d) last=%0b at cycle %0d",
                   out_o.pixel_x, out_o.pixel_y, out_o.last_pixel, cycle_count);
        end
      end else begin
        want = expected_pixels.pop_front();
        if (out_o.pixel_x !== want.pixel_x || out_o.pixel_y !== want.pixel_y ||
            out_o.last_pixel !== want.last_pixel) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("pixel mismatch at cycle %0d: expected (%0d,%0d) last=%0b,",
                     cycle_count, want.pixel_x, want.pixel_y, want.last_pixel);
            $display("  got (%0d,%0d) last=%0b",
                     out_o.pixel_x, out_o.pixel_y, out_o.last_pixel);
          end
        end
      end
    end
  end

  // Advance the walker by one request; return 1 with the pixel it yields.
  function automatic bit rasterize_step(input blr_pkg::blr_req_t r,
                                        output blr_pkg::blr_pix_t p);
    logic signed [blr_pkg::CoordW-1:0] x0, y0, x1, y1, tx, ty;
    int  dx, dy, sa, sb;
    bit  walking;
    p = '0;
    if (r.mode == blr_pkg::BLR_MODE_LOAD) begin
      x0 = r.start_x;
      y0 = r.start_y;
      x1 = r.end_x;
      y1 = r.end_y;
      // Order the endpoints so that x never decreases along the walk.
      if (x0 > x1) begin
        tx = x0;
        ty = y0;
        x0 = x1;
        y0 = y1;
        x1 = tx;
        y1 = ty;
      end
      dx = int'(x1) - int'(x0);
      dy = int'(y1) - int'(y0);
      sa = 2 * dy;
      sb = -2 * dx;
      walker.walk_x   = x0;
      walker.walk_y   = y0;
      walker.target_x = x1;
      walker.target_y = y1;
      walker.step_a   = blr_pkg::StepW'(sa);
      walker.step_b   = blr_pkg::StepW'(sb);
      if ((dx < 0 ? -dx : dx) >= (dy < 0 ? -dy : dy)) begin
        if (sa > 0) begin
          walker.octant   = blr_pkg::OCT_SHALLOW_UP;
          walker.decision = blr_pkg::DecW'(sa + sb / 2);
        end else begin
          walker.octant   = blr_pkg::OCT_SHALLOW_DOWN;
          walker.decision = blr_pkg::DecW'(sa - sb / 2);
        end
      end else begin
        if (sa > 0) begin
          walker.octant   = blr_pkg::OCT_STEEP_UP;
          walker.decision = blr_pkg::DecW'(sa / 2 + sb);
        end else begin
          walker.octant   = blr_pkg::OCT_STEEP_DOWN;
          walker.decision = blr_pkg::DecW'(sa / 2 - sb);
        end
      end
      walker.active = 1'b1;
      return 1'b0;
    end

    if (!walker.active) return 1'b0;

    case (walker.octant)
      blr_pkg::OCT_STEEP_UP:   walking = walker.walk_y < walker.target_y;
      blr_pkg::OCT_STEEP_DOWN: walking = walker.walk_y > walker.target_y;
      default:                 walking = walker.walk_x < walker.target_x;
    endcase

    if (!walking) begin
      p.pixel_x    = walker.target_x;
      p.pixel_y    = walker.target_y;
      p.last_pixel = 1'b1;
      walker.active = 1'b0;
      return 1'b1;
    end

    p.pixel_x    = walker.walk_x;
    p.pixel_y    = walker.walk_y;
    p.last_pixel = 1'b0;

    case (walker.octant)
      blr_pkg::OCT_SHALLOW_UP: begin
        if (walker.decision > 0) begin
          walker.walk_y   = walker.walk_y + 1'b1;
          walker.decision = walker.decision + walker.step_b;
        end
        walker.walk_x   = walker.walk_x + 1'b1;
        walker.decision = walker.decision + walker.step_a;
      end
      blr_pkg::OCT_SHALLOW_DOWN: begin
        if (walker.decision < 0) begin
          walker.walk_y   = walker.walk_y - 1'b1;
          walker.decision = walker.decision - walker.step_b;
        end
        walker.walk_x   = walker.walk_x + 1'b1;
        walker.decision = walker.decision + walker.step_a;
      end
      blr_pkg::OCT_STEEP_UP: begin
        if (walker.decision < 0) begin
          walker.walk_x   = walker.walk_x + 1'b1;
          walker.decision = walker.decision + walker.step_a;
        end
        walker.walk_y   = walker.walk_y + 1'b1;
        walker.decision = walker.decision + walker.step_b;
      end
      default: begin
        if (walker.decision > 0) begin
          walker.walk_x   = walker.walk_x + 1'b1;
          walker.decision = walker.decision + walker.step_a;
        end
        walker.walk_y   = walker.walk_y - 1'b1;
        walker.decision = walker.decision - walker.step_b;
      end
    endcase
    return 1'b1;
  endfunction

  function automatic blr_pkg::blr_req_t make_req(input blr_pkg::blr_mode_e m,
                                                 input int sx, input int sy,
                                                 input int ex, input int ey);
    blr_pkg::blr_req_t r;
    r.mode    = m;
    r.start_x = blr_pkg::CoordW'(sx);
    r.start_y = blr_pkg::CoordW'(sy);
    r.end_x   = blr_pkg::CoordW'(ex);
    r.end_y   = blr_pkg::CoordW'(ey);
    return r;
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(4095)) - 2048;
  endfunction

  // Step requests carry random, ignored coordinates.
  function automatic blr_pkg::blr_req_t rand_step();
    return make_req(blr_pkg::BLR_MODE_STEP, rand_coord(), rand_coord(), rand_coord(),
                    rand_coord());
  endfunction

  // Keep an endpoint in range by mirroring an offset that would leave it.
  function automatic int offset_coord(input int base, input int delta);
    if (base + delta > 2047 || base + delta < -2048) return base - delta;
    return base + delta;
  endfunction

  task automatic add_row(input blr_pkg::blr_mode_e m, input int sx, input int sy,
                         input int ex, input int ey, input exp_kind_e k, input int px,
                         input int py, input bit lp);
    dir_row_t row;
    row.req            = make_req(m, sx, sy, ex, ey);
    row.kind           = k;
    row.pix.pixel_x    = blr_pkg::CoordW'(px);
    row.pix.pixel_y    = blr_pkg::CoordW'(py);
    row.pix.last_pixel = lp;
    dir_rows.push_back(row);
  endtask

  // Drive one request transaction, then record what it should return.
  task automatic send_req(input blr_pkg::blr_req_t r, input exp_kind_e k,
                          input blr_pkg::blr_pix_t typed);
    blr_pkg::blr_pix_t p;
    bit                has_pixel;
    // Drop valid for a random gap; hold it high straight into the next item otherwise.
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_i       <= r;
    do @(posedge clk_i); while (!in_ready_o);
    has_pixel = rasterize_step(r, p);
    case (k)
      EXP_FROM_WALK:   if (has_pixel) expected_pixels.push_back(p);
      EXP_TYPED_PIXEL: expected_pixels.push_back(typed);
      default:         ;
    endcase
  endtask

  task automatic send_walked(input blr_pkg::blr_req_t r);
    if (r.mode == blr_pkg::BLR_MODE_LOAD) lines_loaded++;
    // Steps while idle are ignored by the block and are not counted.
    if (r.mode == blr_pkg::BLR_MODE_LOAD || walker.active) random_count++;
    send_req(r, EXP_FROM_WALK, '0);
  endtask

  initial begin
    int        pick, sx, sy, ex, ey, span, cap, extra, steps;
    bit        full_walk;

    // Idle step after reset, single-point line, then a step on the idle walker.
    add_row(blr_pkg::BLR_MODE_STEP, 0, 0, 0, 0, EXP_NO_PIXEL, 0, 0, 0);
    add_row(blr_pkg::BLR_MODE_LOAD, 5, -7, 5, -7, EXP_NO_PIXEL, 0, 0, 0);
    add_row(blr_pkg::BLR_MODE_STEP, -1, 2047, -2048, 1, EXP_TYPED_PIXEL, 5, -7, 1);
    add_row(blr_pkg::BLR_MODE_STEP, 2047, -2048, 2047, -2048, EXP_NO_PIXEL, 0, 0, 0);
    // Extreme endpoints in reverse x order: swap, then cut short by a new load.
    add_row(blr_pkg::BLR_MODE_LOAD, 2047, 2047, -2048, -2048, EXP_NO_PIXEL, 0, 0, 0);
    add_row(blr_pkg::BLR_MODE_STEP, 0, 0, 0, 0, EXP_TYPED_PIXEL, -2048, -2048, 0);
    add_row(blr_pkg::BLR_MODE_STEP, -1, -1, -1, -1, EXP_FROM_WALK, 0, 0, 0);
    // Shallow rising line.
    add_row(blr_pkg::BLR_MODE_LOAD, 0, 0, 2, 1, EXP_NO_PIXEL, 0, 0, 0);
    add_row(blr_pkg::BLR_MODE_STEP, 0, 0, 0, 0, EXP_TYPED_PIXEL, 0, 0, 0);
    add_row(blr_pkg::BLR_MODE_STEP, 0, 0, 0, 0, EXP_FROM_WALK, 0, 0, 0);
    add_row(blr_pkg::BLR_MODE_STEP, 0, 0, 0, 0, EXP_TYPED_PIXEL, 2, 1, 1);
    // Shallow falling line.
    add_row(blr_pkg::BLR_MODE_LOAD, -1, 0, 1, -1, EXP_NO_PIXEL, 0, 0, 0);
    add_row(blr_pkg::BLR_MODE_STEP, 0, 0, 0, 0, EXP_FROM_WALK, 0, 0, 0);
    add_row(blr_pkg::BLR_MODE_STEP, 0, 0, 0, 0, EXP_FROM_WALK, 0, 0, 0);
    add_row(blr_pkg::BLR_MODE_STEP, 0, 0, 0, 0, EXP_TYPED_PIXEL, 1, -1, 1);
    // Steep rising line.
    add_row(blr_pkg::BLR_MODE_LOAD, 0, 0, 1, 2, EXP_NO_PIXEL, 0, 0, 0);
    add_row(blr_pkg::BLR_MODE_STEP, 0, 0, 0, 0, EXP_FROM_WALK, 0, 0, 0);
    add_row(blr_pkg::BLR_MODE_STEP, 0, 0, 0, 0, EXP_FROM_WALK, 0, 0, 0);
    add_row(blr_pkg::BLR_MODE_STEP, 0, 0, 0, 0, EXP_TYPED_PIXEL, 1, 2, 1);
    // Steep falling line.
    add_row(blr_pkg::BLR_MODE_LOAD, 0, 0, 1, -2, EXP_NO_PIXEL, 0, 0, 0);
    add_row(blr_pkg::BLR_MODE_STEP, 0, 0, 0, 0, EXP_FROM_WALK, 0, 0, 0);
    add_row(blr_pkg::BLR_MODE_STEP, 0, 0, 0, 0, EXP_FROM_WALK, 0, 0, 0);
    add_row(blr_pkg::BLR_MODE_STEP, 0, 0, 0, 0, EXP_TYPED_PIXEL, 1, -2, 1);

    // Hold reset, then release it once.
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct  = 9;
    recv_stall_pct = 65;
    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].kind, dir_rows[i].pix);

    while (random_count < RANDOM_ITEMS) begin
      // Phase 1: sender rarely idles, receiver mostly stalls; phase 2 swaps them;
      // phase 3 runs both sides at full rate.
      if (random_count < RANDOM_ITEMS / 3) begin
        send_idle_pct  = 9;
        recv_stall_pct = 65;
      end else if (random_count < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct  = 65;
        recv_stall_pct = 9;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end

      pick = int'($urandom_range(99));
      if (pick < 8) begin
        // Noise: a fully random transaction of either mode.
        send_walked(make_req(blr_pkg::blr_mode_e'($urandom_range(1)), rand_coord(),
                             rand_coord(), rand_coord(), rand_coord()));
      end else begin
        // Well-formed line: load, then walk it.
        sx = rand_coord();
        sy = rand_coord();
        full_walk = 1'b1;
        if (pick < 13) begin
          ex = rand_coord();
          ey = rand_coord();
          full_walk = 1'b0;
        end else begin
          span = (pick < 23) ? 64 : 12;
          ex = offset_coord(sx, int'($urandom_range(2 * span)) - span);
          ey = offset_coord(sy, int'($urandom_range(2 * span)) - span);
        end
        send_walked(make_req(blr_pkg::BLR_MODE_LOAD, sx, sy, ex, ey));

        // Cut long lines short; break a tenth of the rest early.
        if (!full_walk) cap = int'($urandom_range(40, 5));
        else if ($urandom_range(9) == 0) cap = int'($urandom_range(3));
        else cap = 1000;
        steps = 0;
        while (walker.active && steps < cap) begin
          send_walked(rand_step());
          steps++;
        end
        // Occasionally step the idle walker, which must return nothing.
        if (!walker.active && $urandom_range(9) == 0) begin
          extra = int'($urandom_range(2, 1));
          repeat (extra) send_walked(rand_step());
        end
      end
    end

    // Release the request channel, drain the pixels, then let the pipe settle.
    in_valid_i <= 1'b0;
    recv_stall_pct = 0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d directed rows, %0d random transactions over %0d line loads",
             dir_rows.size(), random_count, lines_loaded);
    $display("checked %0d pixels in %0d cycles, %0d mismatches",
             pixels_seen, cycle_count, mismatches);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
